// File: rtl/vpma_pkg.sv
// shared types, constants and helper functions for the planar memory access unit
package vpma_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int DATA_BITS  = 32;
    localparam int PLANES     = 4;
    localparam int PADDR_BITS = 5;
    localparam int REG_BITS   = 3;

    // register indexes (byte address / 4)
    typedef enum logic [REG_BITS-1:0] {
        REG_READ_CONTROL   = 3'd0,
        REG_COLOR_COMPARE  = 3'd1,
        REG_WRITE_CONTROL  = 3'd2,
        REG_SET_RESET      = 3'd3,
        REG_BIT_MASK       = 3'd4,
        REG_PLANE_WRITE_EN = 3'd5
    } reg_idx_t;

    // write modes
    typedef enum logic [1:0] {
        WMODE_0 = 2'd0,
        WMODE_1 = 2'd1,
        WMODE_2 = 2'd2,
        WMODE_3 = 2'd3
    } wmode_t;

    // logical operations against the latch
    typedef enum logic [1:0] {
        LOP_NONE = 2'd0,
        LOP_AND  = 2'd1,
        LOP_OR   = 2'd2,
        LOP_XOR  = 2'd3
    } lop_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    typedef struct packed {
        logic [2:0] read_control;
        logic [7:0] color_compare_control;
        logic [6:0] write_control;
        logic [7:0] set_reset_control;
        logic [7:0] bit_mask;
        logic [3:0] plane_write_enable;
    } cfg_t;

    // each nibble bit becomes a full byte in its plane
    function automatic logic [DATA_BITS-1:0] plane_fill(input logic [PLANES-1:0] nib);
        logic [DATA_BITS-1:0] r;
        r = '0;
        for (int p = 0; p < PLANES; p++)
        begin
            r[8*p +: 8] = {8{nib[p]}};
        end
        return r;
    endfunction

    // one byte copied into all planes
    function automatic logic [DATA_BITS-1:0] byte_spread(input logic [7:0] b);
        return {PLANES{b}};
    endfunction

endpackage

// File: rtl/vpma_ram.sv
// generic single-port synchronous ram with byte enables and registered read
module vpma_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  we,
    input  logic [DATA_W/8-1:0]   be,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DATA_W-1:0]     wdata,
    output logic [DATA_W-1:0]     rdata
);

    localparam int LANES = DATA_W / 8;

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                for (int b = 0; b < LANES; b++)
                begin
                    if (be[b])
                    begin
                        mem[addr][8*b +: 8] <= wdata[8*b +: 8];
                    end
                end
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vpma_regs.sv
// apb configuration register file
module vpma_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vpma_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output vpma_pkg::cfg_t                   cfg
);

    import vpma_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_READ_CONTROL:   cfg_next.read_control          = pwdata[2:0];
                REG_COLOR_COMPARE:  cfg_next.color_compare_control = pwdata[7:0];
                REG_WRITE_CONTROL:  cfg_next.write_control         = pwdata[6:0];
                REG_SET_RESET:      cfg_next.set_reset_control     = pwdata[7:0];
                REG_BIT_MASK:       cfg_next.bit_mask              = pwdata[7:0];
                REG_PLANE_WRITE_EN: cfg_next.plane_write_enable    = pwdata[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_control          <= '0;
            cfg_reg.color_compare_control <= '0;
            cfg_reg.write_control         <= '0;
            cfg_reg.set_reset_control     <= '0;
            cfg_reg.bit_mask              <= 8'hFF;
            cfg_reg.plane_write_enable    <= 4'hF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_READ_CONTROL:   prdata = {29'd0, cfg_reg.read_control};
            REG_COLOR_COMPARE:  prdata = {24'd0, cfg_reg.color_compare_control};
            REG_WRITE_CONTROL:  prdata = {25'd0, cfg_reg.write_control};
            REG_SET_RESET:      prdata = {24'd0, cfg_reg.set_reset_control};
            REG_BIT_MASK:       prdata = {24'd0, cfg_reg.bit_mask};
            REG_PLANE_WRITE_EN: prdata = {28'd0, cfg_reg.plane_write_enable};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/vpma_write_path.sv
// write data former: rotate, set/reset, logical op and bit mask
module vpma_write_path (
    input  vpma_pkg::cfg_t                    cfg,
    input  logic [7:0]                        host,
    input  logic [vpma_pkg::DATA_BITS-1:0]    latch,
    output logic [vpma_pkg::DATA_BITS-1:0]    wdata
);

    import vpma_pkg::*;

    logic [15:0]          dbl;
    logic [7:0]           rb;
    logic [DATA_BITS-1:0] sr_en;
    logic [DATA_BITS-1:0] sr_val;
    logic [DATA_BITS-1:0] bm;
    logic [DATA_BITS-1:0] op_data;
    logic [DATA_BITS-1:0] op_sel;
    wmode_t               wmode;
    lop_t                 lop;

    assign dbl    = {host, host} >> cfg.write_control[2:0];
    assign rb     = dbl[7:0];
    assign sr_en  = plane_fill(cfg.set_reset_control[7:4]);
    assign sr_val = plane_fill(cfg.set_reset_control[3:0]);
    assign bm     = byte_spread(cfg.bit_mask);
    assign wmode  = wmode_t'(cfg.write_control[6:5]);
    assign lop    = lop_t'(cfg.write_control[4:3]);

    always_comb
    begin
        unique case (wmode)
            WMODE_0:
            begin
                op_data = (byte_spread(rb) & ~sr_en) | (sr_val & sr_en);
                op_sel  = bm;
            end
            WMODE_2:
            begin
                op_data = plane_fill(host[3:0]);
                op_sel  = bm;
            end
            WMODE_3:
            begin
                op_data = sr_val;
                op_sel  = byte_spread(rb) & bm;
            end
            default:
            begin
                op_data = latch;
                op_sel  = '1;
            end
        endcase
    end

    always_comb
    begin
        if (wmode == WMODE_1)
        begin
            wdata = latch;
        end
        else
        begin
            unique case (lop)
                LOP_NONE: wdata = (op_data & op_sel) | (latch & ~op_sel);
                LOP_AND:  wdata = (op_data | ~op_sel) & latch;
                LOP_OR:   wdata = (op_data & op_sel) | latch;
                LOP_XOR:  wdata = (op_data & op_sel) ^ latch;
                default:  wdata = latch;
            endcase
        end
    end

endmodule

// File: rtl/vpma_read_path.sv
// read result former: plane byte select or color compare
module vpma_read_path (
    input  vpma_pkg::cfg_t                    cfg,
    input  logic [vpma_pkg::DATA_BITS-1:0]    word,
    output logic [7:0]                        result
);

    import vpma_pkg::*;

    logic [3:0]           dc;
    logic [3:0]           cc;
    logic [DATA_BITS-1:0] t;
    logic [7:0]           mism;

    assign dc   = cfg.color_compare_control[7:4];
    assign cc   = cfg.color_compare_control[3:0];
    assign t    = (word & plane_fill(dc)) ^ plane_fill(cc & dc);
    assign mism = t[7:0] | t[15:8] | t[23:16] | t[31:24];

    always_comb
    begin
        if (cfg.read_control[2])
        begin
            result = ~mism;
        end
        else
        begin
            result = word[8*cfg.read_control[1:0] +: 8];
        end
    end

endmodule

// File: rtl/vga_planar_memory_access_unit.sv
// top level: four-plane video memory with graphics-controller read and write modes
// flow: an accepted transaction is registered in s1_valid_reg and then in done_reg, which drives done
// throughput: one transaction per cycle while busy is low, set by the single port of the plane memory
// reset: after rst_n releases, a clearing pass zeroes all 65536 words of the plane memory,
//   one word per cycle; busy is high during it, configuration writes are still taken
// the receiver cannot stall: each result is shown for exactly one cycle with done
module vga_planar_memory_access_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // transaction port
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [15:0]                      address,
    input  logic [7:0]                       write_data,
    output logic                             done,
    output logic [7:0]                       read_data,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vpma_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import vpma_pkg::*;

    cfg_t                 cfg;

    // clearing sequencer
    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_BITS-1:0] clear_addr_reg;
    logic [ADDR_BITS-1:0] clear_addr_next;

    // transaction in flight while the memory read completes
    logic                 s1_valid_reg;
    logic                 s1_read_reg;

    // output stage
    logic                 done_reg;
    logic [7:0]           read_data_reg;

    logic [DATA_BITS-1:0] latch_reg;
    logic [DATA_BITS-1:0] latch_eff;

    logic                 accept;
    logic                 ram_en;
    logic                 ram_we;
    logic [PLANES-1:0]    ram_be;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [DATA_BITS-1:0] ram_wdata;
    logic [DATA_BITS-1:0] ram_rdata;
    logic [DATA_BITS-1:0] wr_word;
    logic [7:0]           rd_result;

    vpma_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state machine for the post-reset clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == {ADDR_BITS{1'b1}})
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy   = (state_reg == ST_CLEAR);
    assign accept = start && !busy;

    // a read just issued has its word on ram_rdata now; a write right behind it
    // must combine with that word, not the stale latch
    assign latch_eff = (s1_valid_reg && s1_read_reg) ? ram_rdata : latch_reg;

    vpma_write_path u_write_path (
        .cfg   (cfg),
        .host  (write_data),
        .latch (latch_eff),
        .wdata (wr_word)
    );

    // memory port: the clearing pass owns it until the run state
    always_comb
    begin
        if (busy)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_be    = '1;
            ram_addr  = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_en    = accept;
            ram_we    = action;
            ram_be    = cfg.plane_write_enable;
            ram_addr  = address[ADDR_BITS-1:0];
            ram_wdata = wr_word;
        end
    end

    vpma_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (DATA_BITS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .be    (ram_be),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vpma_read_path u_read_path (
        .cfg    (cfg),
        .word   (ram_rdata),
        .result (rd_result)
    );

    // pipeline control and latch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_read_reg  <= 1'b0;
            done_reg     <= 1'b0;
            latch_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_read_reg  <= accept && !action;
            done_reg     <= s1_valid_reg;
            latch_reg    <= latch_eff;
        end
    end

    // result payload; a write returns zero
    always_ff @(posedge clk)
    begin
        read_data_reg <= s1_read_reg ? rd_result : 8'd0;
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;

endmodule
